// ----- rtl/sdp_pkg.sv -----
// sdp_pkg: constants, types and weight function for the smoothstep decay purge block
// no dependencies
package sdp_pkg;
	localparam int unsigned NSTEPS = 256;
	localparam int unsigned NLOG2  = 8;
	localparam int unsigned IDX_W  = NLOG2;
	localparam int unsigned CNT_W  = NLOG2 + 1;
	localparam int unsigned SIZE_W = 48;
	localparam int unsigned TIME_W = 64;
	localparam int unsigned PER_W  = 42;
	// largest weight is N*N at the last step
	localparam int unsigned W_W    = 2 * NLOG2 + 1;
	localparam int unsigned ACC_W  = SIZE_W + W_W + NLOG2 + 1;
	localparam logic [PER_W-1:0] PERIOD_RST = PER_W'(64'd10000000000);
	localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIV   = 7'b0000010,
		ST_MUL   = 7'b0000100,
		ST_CLR   = 7'b0001000,
		ST_WR    = 7'b0010000,
		ST_ACC   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	// smoothstep weight for step s in 1..N
	function automatic logic [W_W-1:0] step_weight(input logic [CNT_W-1:0] s);
		logic [3*CNT_W+2:0] p;
		p = (3*CNT_W+3)'(s) * (3*CNT_W+3)'(s)
			* ((3*CNT_W+3)'(3 * NSTEPS) - ((3*CNT_W+3)'(s) << 1));
		return W_W'(p >> NLOG2);
	endfunction
endpackage

// ----- rtl/sdp_if.sv -----
// sdp_if: valid/ready channel with a generic payload
// depends on nothing
interface sdp_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/sdp_ram.sv -----
// sdp_ram: generic single-port ram with registered read
// no dependencies
module sdp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// ----- rtl/sdp_div.sv -----
// sdp_div: restoring divider, one quotient bit per cycle
// depends on sdp_pkg
module sdp_div import sdp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] num,
	input  logic [PER_W-1:0]  den,
	output logic              busy,
	output logic [TIME_W-1:0] quo,
	output logic [PER_W-1:0]  rem
);
	logic [6:0]        cnt_q;
	logic [TIME_W-1:0] q_q;
	logic [PER_W:0]    rem_q;
	logic [PER_W:0]    sh;
	always_comb sh = {rem_q[PER_W-1:0], q_q[TIME_W-1]};
	assign busy = cnt_q != 7'd0;
	assign quo = q_q;
	// remainder is below the divisor, top bit always clear
	assign rem = rem_q[PER_W-1:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'(TIME_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			rem_q <= '0;
		end else if (busy) begin
			if (sh >= {1'b0, den}) begin
				rem_q <= sh - {1'b0, den};
				q_q <= {q_q[TIME_W-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				q_q <= {q_q[TIME_W-2:0], 1'b0};
			end
		end
	end
endmodule

// ----- rtl/smoothstep_decay_purge_core.sv -----
// smoothstep_decay_purge_core: top level, sequencer, ring, accumulator
// depends on sdp_pkg, sdp_if, sdp_ram, sdp_div
//
// channel  dir  payload
// in       in   cmd, cur_time_ns, current_size
// out      out  purge_size, epoch_taken, restarted
// cfg      in   cfg_we, cfg_wdata (decay_period_ns)
//
// restart or no-boundary items: result valid the cycle after the input transfer
// epoch query: divide, epoch start update, clear of the n skipped slots
// (n up to 256), write, accumulate walk, result
// reset clears the 256-entry ring in a clearing pass; no input taken then
// the output register holds until transferred; next item taken after that
module smoothstep_decay_purge_core import sdp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [PER_W-1:0] cfg_wdata,
	sdp_if.sink   in_ch,
	sdp_if.source out_ch
);
	typedef struct packed {
		logic              cmd;
		logic [TIME_W-1:0] cur_time_ns;
		logic [SIZE_W-1:0] current_size;
	} in_t;
	typedef struct packed {
		logic [SIZE_W-1:0] purge_size;
		logic              epoch_taken;
		logic              restarted;
	} out_t;

	in_t  in_d;
	out_t out_q;
	assign in_d = in_ch.data;
	assign out_ch.data = out_q;

	logic [PER_W-1:0]  period_q;
	state_t            st_q;
	logic              init_q;      // reset clearing pass in progress
	logic [IDX_W-1:0]  cur_q;
	logic [TIME_W-1:0] start_q;
	logic [SIZE_W-1:0] resv_q;
	logic [TIME_W-1:0] now_q;
	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0]  cnt_q;       // generic step counter
	logic [CNT_W-1:0]  nclr_q;
	logic              out_v_q;
	logic [ACC_W-1:0]  acc_q;
	logic [W_W-1:0]    prod_w_s1;
	logic              acc_v_s1, acc_v_s2;
	logic [SIZE_W+W_W-1:0] prod_s2;

	// epoch interval, zero forced to one
	logic [PER_W-1:0] iv;
	always_comb begin
		iv = period_q >> NLOG2;
		if (iv == '0) iv = PER_W'(1);
	end

	// divider for the whole epoch count and the leftover past the last boundary
	logic div_start, div_busy;
	logic [TIME_W-1:0] quo;
	logic [PER_W-1:0] rem;
	sdp_div u_div (.clk, .arst_n, .start(div_start), .num(now_q - start_q),
		.den(iv), .busy(div_busy), .quo, .rem);

	// ring ram, one port shared by clear, write and accumulate walk
	logic ram_we;
	logic [IDX_W-1:0] ram_a;
	logic [SIZE_W-1:0] ram_wd, ram_rd;
	sdp_ram #(.WIDTH(SIZE_W), .DEPTH(NSTEPS)) u_ring (.clk, .we(ram_we),
		.addr(ram_a), .wdata(ram_wd), .rdata(ram_rd));

	logic [IDX_W-1:0] newest;
	assign newest = cur_q - IDX_W'(1);

	always_comb begin
		ram_we = 1'b0;
		ram_a = cur_q + cnt_q[IDX_W-1:0];
		ram_wd = '0;
		if (init_q) begin
			ram_we = 1'b1;
			ram_a = cnt_q[IDX_W-1:0];
		end else if (st_q == ST_CLR) begin
			ram_we = cnt_q < nclr_q;
		end else if (st_q == ST_WR) begin
			ram_we = 1'b1;
			ram_a = newest;
			ram_wd = (size_q > resv_q) ? size_q - resv_q : '0;
		end
	end

	assign in_ch.ready = (st_q == ST_IDLE) && !init_q && !out_v_q;
	assign out_ch.valid = out_v_q;
	assign div_start = (st_q == ST_DIV) && !div_busy && (cnt_q == '0);

	// reserve from accumulator: shift by 2*log2 N and saturate
	logic [ACC_W-1:0] sh_acc;
	logic [SIZE_W-1:0] resv_new;
	always_comb begin
		sh_acc = acc_q >> (2 * NLOG2);
		resv_new = (sh_acc > ACC_W'(SIZE_MAX)) ? SIZE_MAX : sh_acc[SIZE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			st_q <= ST_IDLE;
			init_q <= 1'b1;
			cur_q <= '0;
			start_q <= '0;
			resv_q <= '0;
			cnt_q <= '0;
			out_v_q <= 1'b0;
			acc_v_s1 <= 1'b0;
			acc_v_s2 <= 1'b0;
		end else begin
			if (cfg_we) period_q <= cfg_wdata;
			if (out_ch.valid && out_ch.ready) out_v_q <= 1'b0;
			// a ring read is issued on every walk step
			acc_v_s1 <= (st_q == ST_ACC) && (cnt_q != CNT_W'(NSTEPS));
			acc_v_s2 <= acc_v_s1;
			if (init_q) begin
				if (cnt_q == CNT_W'(NSTEPS - 1)) begin
					init_q <= 1'b0;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end else begin
				case (st_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						now_q <= in_d.cur_time_ns;
						size_q <= in_d.current_size;
						cnt_q <= '0;
						if (in_d.cmd || in_d.cur_time_ns <= start_q) begin
							start_q <= in_d.cur_time_ns;
							out_q <= '{purge_size: '0, epoch_taken: 1'b0, restarted: 1'b1};
							out_v_q <= 1'b1;
						end else if (in_d.cur_time_ns - start_q <= TIME_W'(iv)) begin
							out_q <= '0;
							out_v_q <= 1'b1;
						end else begin
							st_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_start) cnt_q <= CNT_W'(1);
					else if (!div_busy) begin
						cnt_q <= '0;
						st_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// start plus whole epochs equals now minus the remainder
					start_q <= now_q - TIME_W'(rem);
					if (quo >= TIME_W'(NSTEPS)) begin
						nclr_q <= CNT_W'(NSTEPS);
					end else begin
						nclr_q <= CNT_W'(quo);
					end
					st_q <= ST_CLR;
				end
				ST_CLR: begin
					if (cnt_q >= nclr_q) begin
						if (nclr_q == CNT_W'(NSTEPS)) cur_q <= '0;
						else cur_q <= cur_q + nclr_q[IDX_W-1:0];
						cnt_q <= '0;
						st_q <= ST_WR;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_WR: begin
					acc_q <= '0;
					cnt_q <= '0;
					st_q <= ST_ACC;
				end
				ST_ACC: begin
					if (cnt_q != CNT_W'(NSTEPS)) begin
						prod_w_s1 <= step_weight(cnt_q + CNT_W'(1));
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (!acc_v_s1 && !acc_v_s2) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					resv_q <= resv_new;
					out_q <= '{purge_size: (size_q > resv_new) ? size_q - resv_new : '0,
						epoch_taken: 1'b1, restarted: 1'b0};
					out_v_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
				endcase
				if (acc_v_s2) acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	// multiply stage: ram data arrives the cycle after its address
	always_ff @(posedge clk) begin
		prod_s2 <= (SIZE_W+W_W)'(ram_rd) * (SIZE_W+W_W)'(prod_w_s1);
	end

`ifndef SYNTHESIS
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result lost");
	a_init_idle: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> (st_q == ST_IDLE)) else $error("work during clear pass");
`endif
endmodule
